// ----- hdl/sssp_pkg.sv -----
package sssp_pkg;

  localparam int unsigned VertexBits = 6;
  localparam int unsigned WeightPortBits = 16;
  localparam int unsigned DistBits = 32;
  localparam int unsigned CountBits = 7;
  localparam logic [DistBits-1:0] IntMax = 32'h7FFF_FFFF;
  localparam logic [CountBits-1:0] VertexCountReset = 7'd64;

  typedef struct packed {
    logic [VertexBits-1:0]     from_vertex;
    logic [VertexBits-1:0]     to_vertex;
    logic [WeightPortBits-1:0] edge_weight;
    logic                      last_edge;
    logic [VertexBits-1:0]     start_vertex;
  } edge_req_t;

  typedef struct packed {
    logic [VertexBits-1:0] vertex_id;
    logic [DistBits-1:0]   path_length;
    logic                  reachable;
    logic                  negative_cycle;
    logic                  last_result;
  } dist_rsp_t;

endpackage

// ----- hdl/sssp_if.sv -----
interface sssp_edge_if;
  logic                valid;
  logic                ready;
  sssp_pkg::edge_req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sssp_rsp_if;
  logic                valid;
  logic                ready;
  sssp_pkg::dist_rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/sssp_front.sv -----
module sssp_front #(
  parameter int unsigned WeightBits = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sssp_pkg::edge_req_t in_req_i,
  output logic q_valid_o,
  input  logic q_ready_i,
  output sssp_pkg::edge_req_t q_req_o
);

  localparam int unsigned Depth = 2;

  sssp_pkg::edge_req_t fifo_q [Depth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  sssp_pkg::edge_req_t req_x;

  always_comb begin
    req_x = in_req_i;
    req_x.edge_weight = sssp_pkg::WeightPortBits'(
      $signed(in_req_i.edge_weight[WeightBits-1:0]));
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop = q_valid_o && q_ready_i;
  assign q_req_o = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= req_x;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- hdl/sssp_back.sv -----
module sssp_back #(
  parameter int unsigned MaxVertices = 64,
  parameter int unsigned MaxEdges = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic [sssp_pkg::CountBits-1:0] vertex_count_i,
  input  logic q_valid_i,
  output logic q_ready_o,
  input  sssp_pkg::edge_req_t q_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output sssp_pkg::dist_rsp_t out_rsp_o
);

  localparam int unsigned EAw = (MaxEdges > 1) ? $clog2(MaxEdges) : 1;
  localparam int unsigned ECw = $clog2(MaxEdges + 1);
  localparam int unsigned VAw = $clog2(MaxVertices);
  localparam int unsigned VCw = $clog2(MaxVertices + 1);
  localparam int unsigned VB = sssp_pkg::VertexBits;
  localparam int unsigned DB = sssp_pkg::DistBits;

  localparam logic [2:0] StLoad  = 3'd0;
  localparam logic [2:0] StInit  = 3'd1;
  localparam logic [2:0] StRdE   = 3'd2;
  localparam logic [2:0] StRdD   = 3'd3;
  localparam logic [2:0] StRelax = 3'd4;
  localparam logic [2:0] StOutRd = 3'd5;
  localparam logic [2:0] StOut   = 3'd6;

  logic [2:0] state_q;
  logic [ECw-1:0] edges_q, eidx_q;
  logic [VCw-1:0] nv_q, vidx_q;
  logic [VCw-1:0] pass_q;
  logic [VB-1:0] start_q;
  logic cyc_q;

  logic [2*VB+sssp_pkg::WeightPortBits-1:0] emem [MaxEdges];
  logic [2*VB+sssp_pkg::WeightPortBits-1:0] erd_q;
  logic [DB:0] dmem [MaxVertices];
  logic [DB:0] du_q, dv_q;

  logic [VB-1:0] eu, ev;
  logic signed [sssp_pkg::WeightPortBits-1:0] ew;
  assign {eu, ev, ew} = erd_q;

  logic [VCw-1:0] nv_eff;
  always_comb begin
    if (vertex_count_i == '0) nv_eff = VCw'(1);
    else if (32'(vertex_count_i) > MaxVertices) nv_eff = VCw'(MaxVertices);
    else nv_eff = VCw'(vertex_count_i);
  end

  logic signed [DB+1:0] sum_w;
  logic signed [DB-1:0] cand;
  logic signed [DB-1:0] cur;
  logic edge_in, better;
  always_comb begin
    sum_w = (DB+2)'($signed(du_q[DB-1:0])) + (DB+2)'(ew);
    if (sum_w > (DB+2)'($signed(sssp_pkg::IntMax))) cand = $signed(sssp_pkg::IntMax);
    else if (sum_w < -(DB+2)'($signed(sssp_pkg::IntMax)) - 1)
      cand = $signed(~sssp_pkg::IntMax);
    else cand = sum_w[DB-1:0];
    cur = dv_q[DB] ? $signed(dv_q[DB-1:0]) : $signed(sssp_pkg::IntMax);
    edge_in = (VCw'(eu) < nv_q) && (VCw'(ev) < nv_q);
    better = edge_in && du_q[DB] && (cur > cand);
  end

  logic accept;
  assign q_ready_o = (state_q == StLoad);
  assign accept = q_valid_i && q_ready_o;

  logic final_pass;
  assign final_pass = (pass_q + VCw'(1) >= nv_q);

  always_ff @(posedge clk_i) begin
    if (accept && edges_q < ECw'(MaxEdges)) begin
      emem[edges_q[EAw-1:0]] <= {q_req_i.from_vertex, q_req_i.to_vertex,
                                 q_req_i.edge_weight};
    end
    if (state_q == StRdE) erd_q <= emem[eidx_q[EAw-1:0]];
    if (state_q == StRdD) begin
      du_q <= dmem[eu[VAw-1:0]];
      dv_q <= dmem[ev[VAw-1:0]];
    end
    if (state_q == StOutRd) du_q <= dmem[vidx_q[VAw-1:0]];
    if (state_q == StInit) begin
      dmem[vidx_q[VAw-1:0]] <= (VB'(vidx_q) == start_q) ? {1'b1, {DB{1'b0}}}
                                                       : {1'b0, sssp_pkg::IntMax};
    end else if (state_q == StRelax && better && !final_pass) begin
      dmem[ev[VAw-1:0]] <= {1'b1, cand};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      edges_q <= '0;
      eidx_q  <= '0;
      nv_q    <= '0;
      vidx_q  <= '0;
      pass_q  <= '0;
      start_q <= '0;
      cyc_q   <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      case (state_q)
        StLoad: begin
          if (accept) begin
            if (edges_q < ECw'(MaxEdges)) edges_q <= edges_q + ECw'(1);
            if (q_req_i.last_edge) begin
              nv_q    <= nv_eff;
              start_q <= q_req_i.start_vertex;
              vidx_q  <= '0;
              pass_q  <= '0;
              cyc_q   <= 1'b0;
              state_q <= StInit;
            end
          end
        end
        StInit: begin
          if (vidx_q + VCw'(1) >= nv_q) begin
            eidx_q <= '0;
            state_q <= (edges_q == '0) ? StOutRd : StRdE;
            vidx_q <= '0;
          end else begin
            vidx_q <= vidx_q + VCw'(1);
          end
        end
        StRdE: state_q <= StRdD;
        StRdD: state_q <= StRelax;
        StRelax: begin
          if (final_pass && better) cyc_q <= 1'b1;
          if (eidx_q + ECw'(1) >= edges_q) begin
            eidx_q <= '0;
            if (final_pass) begin
              vidx_q <= '0;
              state_q <= StOutRd;
            end else begin
              pass_q <= pass_q + VCw'(1);
              state_q <= StRdE;
            end
          end else begin
            eidx_q <= eidx_q + ECw'(1);
            state_q <= StRdE;
          end
        end
        StOutRd: begin
          state_q <= StOut;
          out_valid_o <= 1'b1;
        end
        StOut: begin
          if (out_ready_i) begin
            out_valid_o <= 1'b0;
            if (vidx_q + VCw'(1) >= nv_q) begin
              edges_q <= '0;
              state_q <= StLoad;
            end else begin
              vidx_q <= vidx_q + VCw'(1);
              state_q <= StOutRd;
            end
          end
        end
        default: state_q <= StLoad;
      endcase
    end
  end

  always_comb begin
    out_rsp_o.vertex_id      = VB'(vidx_q);
    out_rsp_o.path_length    = du_q[DB] ? du_q[DB-1:0] : sssp_pkg::IntMax;
    out_rsp_o.reachable      = du_q[DB];
    out_rsp_o.negative_cycle = cyc_q;
    out_rsp_o.last_result    = (vidx_q + VCw'(1) == nv_q);
  end

endmodule

// ----- hdl/single_source_shortest_path.sv -----
// channel    | dir | payload                                         | handshake
// edge_in    | in  | from/to vertex, edge_weight, last_edge, start   | valid/ready
// dist_out   | out | vertex_id, path_length, reachable, flags        | valid/ready
// cfg        | in  | vertex_count                                    | we only
// edges load at one per cycle while the core is loading, through a two-entry queue into the edge memory
// the solve steps each edge through edge read, distance read and relax, vertex_count
// passes in all; the last pass updates nothing and only flags a negative cycle
// init writes each vertex's distance in turn; each result is read (StOutRd), then offered (StOut)
// input stalls during solve and output; reset clears control only
module single_source_shortest_path #(
  parameter int unsigned MaxVertices = 64,
  parameter int unsigned MaxEdges = 256,
  parameter int unsigned WeightBits = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [sssp_pkg::CountBits-1:0] cfg_wdata_i,
  sssp_edge_if.sink edge_in,
  sssp_rsp_if.source dist_out
);

  logic [sssp_pkg::CountBits-1:0] vertex_count_q;
  logic q_valid, q_ready;
  sssp_pkg::edge_req_t q_req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vertex_count_q <= sssp_pkg::VertexCountReset;
    else if (cfg_we_i) vertex_count_q <= cfg_wdata_i;
  end

  sssp_front #(.WeightBits(WeightBits)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(edge_in.valid), .in_ready_o(edge_in.ready), .in_req_i(edge_in.payload),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_req_o(q_req)
  );

  sssp_back #(.MaxVertices(MaxVertices), .MaxEdges(MaxEdges)) u_back (
    .clk_i, .rst_ni, .vertex_count_i(vertex_count_q),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_req_i(q_req),
    .out_valid_o(dist_out.valid), .out_ready_i(dist_out.ready),
    .out_rsp_o(dist_out.payload)
  );

endmodule

// ----- hdl/sssp_checker.sv -----
module sssp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid,
  input logic out_ready,
  input sssp_pkg::dist_rsp_t out_rsp
);

  logic [sssp_pkg::VertexBits-1:0] next_id_q, next_id_d;

  always_comb begin
    next_id_d = next_id_q;
    if (out_valid && out_ready) begin
      next_id_d = out_rsp.last_result ? '0
                                      : out_rsp.vertex_id + sssp_pkg::VertexBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) next_id_q <= '0;
    else next_id_q <= next_id_d;
  end

  // result held while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_rsp))
    else $error("result changed under stall");

  // unreachable reads as the maximum distance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_rsp.reachable |-> out_rsp.path_length == sssp_pkg::IntMax)
    else $error("unreachable distance wrong");

  // results ascend by one within a solve, starting at vertex 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_rsp.vertex_id == next_id_q)
    else $error("result vertex out of order");

endmodule

bind single_source_shortest_path sssp_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .out_valid(dist_out.valid), .out_ready(dist_out.ready), .out_rsp(dist_out.payload)
);
